/* design/pep_pkg.sv */
// Package for the postfix expression evaluator: token kinds, status codes,
// sequencer states and small helper functions. Depends on nothing.
package pep_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [8:0] DIGIT_BASE = 9'd48;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  localparam logic [47:0] Q_MAX = 48'h7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    TK_PUSH,
    TK_ADD,
    TK_SUB,
    TK_MUL,
    TK_DIV
  } pep_kind_t;

  typedef struct packed {
    pep_kind_t        kind;
    logic signed [8:0] digit;
    logic             last;
  } pep_tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_EX,
    S_DIV,
    S_EMIT
  } pep_state_t;

  // Integer part of a Q32.16 value, truncated toward zero.
  function automatic logic [31:0] trunc_int(input logic [47:0] v);
    logic [47:0] t;
    t = v + (v[47] ? 48'h0000_0000_FFFF : 48'h0);
    return t[47:16];
  endfunction

  // Keep the first error of an expression.
  function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

/* design/pep_front.sv */
// Front end: accepts characters, classifies them into tokens and queues them.
// Depends on pep_pkg.
module pep_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // symbol[7:0]
  input  logic              s_tlast,
  output logic              tok_valid,
  input  logic              tok_ready,
  output pep_pkg::pep_tok_t tok
);

  localparam int QAW = $clog2(pep_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(pep_pkg::QUEUE_DEPTH + 1);

  pep_pkg::pep_tok_t q_mem [pep_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] level;
  pep_pkg::pep_tok_t dec;
  logic push;
  logic pop;

  always_comb begin
    dec.last  = s_tlast;
    dec.digit = $signed({1'b0, s_tdata}) - $signed(pep_pkg::DIGIT_BASE);
    unique case (s_tdata)
      pep_pkg::CH_PLUS:  dec.kind = pep_pkg::TK_ADD;
      pep_pkg::CH_MINUS: dec.kind = pep_pkg::TK_SUB;
      pep_pkg::CH_STAR:  dec.kind = pep_pkg::TK_MUL;
      pep_pkg::CH_SLASH: dec.kind = pep_pkg::TK_DIV;
      default:           dec.kind = pep_pkg::TK_PUSH;
    endcase
  end

  assign s_tready  = (level != QCW'(pep_pkg::QUEUE_DEPTH));
  assign tok_valid = (level != '0);
  assign tok       = q_mem[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = tok_valid && tok_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

/* design/pep_div.sv */
// Iterative signed divider: (a * 2^16) / b in Q32.16, one quotient bit per cycle.
// Depends on pep_pkg.
module pep_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [47:0] q
);

  logic [32:0] rem;
  logic [47:0] n;
  logic [31:0] bmag;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [47:0] num;
  logic [32:0] rem_sh;
  logic        ge;

  assign num    = {a, 16'h0};
  assign rem_sh = {rem[31:0], n[47]};
  assign ge     = (rem_sh >= {1'b0, bmag});

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= a[31] ^ b[31];
      n    <= num[47] ? (48'h0 - num) : num;
      bmag <= b[31] ? (32'h0 - b) : b;
      rem  <= '0;
      cnt  <= 6'd48;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, bmag}) : rem_sh;
      n   <= {n[46:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start)                     busy <= 1'b1;
      else if (busy && cnt == 6'd1) busy <= 1'b0;
    end
  end

  // Only the most negative integer over minus one exceeds the positive range.
  assign q = neg ? (48'h0 - n) : (n[47] ? pep_pkg::Q_MAX : n);

endmodule

/* design/pep_back.sv */
// Back end: operand stack in memory with a cached top entry, the operator
// sequencer and the result register. Depends on pep_pkg and pep_div.
module pep_back #(
  parameter int STACK_DEPTH = pep_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_ready,
  input  pep_pkg::pep_tok_t tok,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,
  output logic [1:0]        m_tuser
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [47:0] stack_mem [STACK_DEPTH];
  logic [47:0] rd_data;

  pep_pkg::pep_state_t state, state_next;
  pep_pkg::pep_tok_t   cur, cur_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    err, err_next;
  logic [47:0]   tos, tos_next;
  logic [31:0]   a_int, a_int_next;
  logic [31:0]   b_int, b_int_next;
  logic          out_valid_next;
  logic [47:0]   out_value_next;
  logic [1:0]    out_status_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] cm1;
  logic [CW-1:0] cm2;
  logic [63:0]   prod;
  logic [47:0]   push_val;
  logic          div_start;
  logic          div_done;
  logic [47:0]   div_q;

  assign cm1      = count - 1'b1;
  assign cm2      = count - 2'd2;
  assign prod     = a_int * b_int;
  assign push_val = {{23{tok.digit[8]}}, tok.digit, 16'h0};

  pep_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (a_int),
    .b     (b_int),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= tos;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    count_next      = count;
    err_next        = err;
    tos_next        = tos;
    a_int_next      = a_int;
    b_int_next      = b_int;
    out_valid_next  = m_tvalid && !m_tready;
    out_value_next  = m_tdata;
    out_status_next = m_tuser;
    mem_we          = 1'b0;
    mem_waddr       = cm1[AW-1:0];
    rd_en           = 1'b0;
    rd_addr         = cm2[AW-1:0];
    tok_ready       = 1'b0;
    div_start       = 1'b0;
    unique case (state)
      pep_pkg::S_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          cur_next = tok;
          if (tok.kind == pep_pkg::TK_PUSH) begin
            if (count == CW'(STACK_DEPTH)) begin
              err_next = pep_pkg::note_err(err, pep_pkg::ST_OVER);
            end else begin
              mem_we     = (count != '0);
              tos_next   = push_val;
              count_next = count + 1'b1;
            end
            if (tok.last) state_next = pep_pkg::S_EMIT;
          end else begin
            rd_en      = 1'b1;
            state_next = pep_pkg::S_OP;
          end
        end
      end
      pep_pkg::S_OP: begin
        b_int_next = pep_pkg::trunc_int((count != '0) ? tos : 48'h0);
        a_int_next = pep_pkg::trunc_int((count >= CW'(2)) ? rd_data : 48'h0);
        if (count < CW'(2)) begin
          err_next   = pep_pkg::note_err(err, pep_pkg::ST_UNDER);
          count_next = CW'(1);
        end else begin
          count_next = cm1;
        end
        state_next = pep_pkg::S_EX;
      end
      pep_pkg::S_EX: begin
        state_next = cur.last ? pep_pkg::S_EMIT : pep_pkg::S_IDLE;
        unique case (cur.kind)
          pep_pkg::TK_ADD: tos_next = {a_int + b_int, 16'h0};
          pep_pkg::TK_SUB: tos_next = {a_int - b_int, 16'h0};
          pep_pkg::TK_MUL: tos_next = {prod[31:0], 16'h0};
          default: begin
            if (b_int == '0) begin
              err_next = pep_pkg::note_err(err, pep_pkg::ST_DIV0);
              tos_next = '0;
            end else begin
              div_start  = 1'b1;
              state_next = pep_pkg::S_DIV;
            end
          end
        endcase
      end
      pep_pkg::S_DIV: begin
        if (div_done) begin
          tos_next   = div_q;
          state_next = cur.last ? pep_pkg::S_EMIT : pep_pkg::S_IDLE;
        end
      end
      pep_pkg::S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_valid_next  = 1'b1;
          out_value_next  = (count != '0) ? tos : 48'h0;
          out_status_next = (count != '0) ? err
                                          : pep_pkg::note_err(err, pep_pkg::ST_UNDER);
          count_next      = '0;
          err_next        = pep_pkg::ST_OK;
          state_next      = pep_pkg::S_IDLE;
        end
      end
      default: state_next = pep_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pep_pkg::S_IDLE;
      count    <= '0;
      err      <= pep_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      err      <= err_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    tos     <= tos_next;
    a_int   <= a_int_next;
    b_int   <= b_int_next;
    m_tdata <= out_value_next;
    m_tuser <= out_status_next;
  end

endmodule

/* design/postfix_expression_evaluator.sv */
// Top level of the postfix expression evaluator.
// Depends on pep_pkg, pep_front and pep_back.
//
// The block evaluates a postfix expression sent one character per item on
// the input stream. The characters + - * / are operators; every other
// character pushes (code - 48) as a whole number in Q32.16. An operator pops
// b then a, truncates both toward zero to 32-bit integers and pushes the sum,
// difference or product (wrapping at 32 bits) or the Q32.16 quotient. The
// item marked by tlast produces one result item: the top of the stack and the
// first error of the expression (0 ok, 1 underflow, 2 overflow, 3 divide by
// zero), after which the stack is empty again. A four-entry token queue sits
// between the character classifier and the stack sequencer. An operand is
// taken in the idle step of the sequencer; +, - and * pass through stack
// read, truncation and execute, and / also waits for the bit-serial divider,
// which finds one of 48 quotient bits per cycle. The result item waits in an
// output register, so the sequencer only stalls when a second result is
// ready before the first one is taken.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pep_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // symbol[7:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value[47:0], signed Q32.16
  output logic [1:0]  m_tuser    // status[1:0]
);

  pep_pkg::pep_tok_t tok;
  logic              tok_valid;
  logic              tok_ready;

  pep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  pep_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // The input side only backs up when the token queue holds something.
  a_full_queue_not_empty: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> tok_valid)
    else $error("input stalled while token queue is empty");

  // A new result is loaded only from the emit step, where no token is taken.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!tok_ready))
    else $error("result appeared while the sequencer was taking tokens");

endmodule
